>>> design/wsc_pkg.sv
// ----------------------------------------------------------------------------
// wsc_pkg
// shared types, constants and the arctangent table of the steering controller
// ----------------------------------------------------------------------------
package wsc_pkg;

    // register indexes of the configuration port
    localparam logic [3:0] CFG_TARGET_X   = 4'd0;
    localparam logic [3:0] CFG_TARGET_Y   = 4'd1;
    localparam logic [3:0] CFG_HEAD_P     = 4'd2;
    localparam logic [3:0] CFG_HEAD_I     = 4'd3;
    localparam logic [3:0] CFG_HEAD_D     = 4'd4;
    localparam logic [3:0] CFG_DIST_P     = 4'd5;
    localparam logic [3:0] CFG_DIST_D     = 4'd6;
    localparam logic [3:0] CFG_SPEED_LIM  = 4'd7;

    // register reset values
    localparam logic [31:0] RST_HEAD_P    = 32'd167772;
    localparam logic [31:0] RST_HEAD_I    = 32'd0;
    localparam logic [31:0] RST_HEAD_D    = 32'd503;
    localparam logic [31:0] RST_DIST_P    = 32'd8388608;
    localparam logic [31:0] RST_DIST_D    = 32'd1174405;
    localparam logic [20:0] RST_SPEED_LIM = 21'd65536;

    // thresholds
    localparam logic [32:0]        ARRIVE_MIN      = 33'd19661;
    localparam logic [32:0]        REACH_LIMIT     = 33'd6554;
    localparam logic signed [16:0] GATE_DEG        = 17'sd256;
    localparam logic signed [16:0] DEAD_DEG        = 17'sd26;
    localparam logic signed [55:0] YAW_MAX         = 56'sd39322;
    localparam logic signed [16:0] RESET_GATE_DEG  = 17'sd1280;
    localparam logic [32:0]        RESET_GATE_DIST = 33'd327680;
    localparam logic signed [33:0] QUARTER_TURN    = 34'sd1073741824;

    // operand width of the serial multiplier
    localparam int MW = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HGATE,
        ST_BEAR,
        ST_ERR,
        ST_MUL,
        ST_HFIN,
        ST_DGATE,
        ST_ROOT,
        ST_DFIN,
        ST_OUT
    } wsc_state_t;

    // products formed on the shared multiplier, in issue order
    typedef enum logic [2:0] {
        J_HP,
        J_HD,
        J_HI,
        J_SQX,
        J_SQY,
        J_DP,
        J_DD
    } wsc_job_t;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_NORM,
        COR_ITER,
        COR_FIN
    } cor_phase_t;

    // atan(2^-i), 2^32 units per turn
    function automatic logic [31:0] cordic_angle(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

>>> design/wsc_mul.sv
// ----------------------------------------------------------------------------
// wsc_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module wsc_mul
    import wsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MW-1:0]       a,
    input  logic [MW-1:0]       b,
    output logic                done,
    output logic [2*MW-1:0]     prod
);

    logic [2*MW-1:0] acc_reg;
    logic [2*MW-1:0] acc_next;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [MW:0]     upper;

    // add the multiplicand into the top half when the low bit is set, then shift
    always_comb
    begin
        upper    = {1'b0, acc_reg[2*MW-1:MW]} + (acc_reg[0] ? {1'b0, a} : {(MW+1){1'b0}});
        acc_next = {upper, acc_reg[MW-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(MW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product register, multiplier bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
            acc_reg <= {{MW{1'b0}}, b};
        else if (busy_reg)
            acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> design/wsc_sqrt.sv
// ----------------------------------------------------------------------------
// wsc_sqrt
// restoring square root, one radicand bit pair per cycle, rounded to nearest
// ----------------------------------------------------------------------------
module wsc_sqrt
    import wsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [65:0]  rad,
    output logic         done,
    output logic [32:0]  root
);

    logic [65:0] rad_reg;
    logic [36:0] rem_reg;
    logic [32:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [36:0] rem_sh;
    logic [36:0] trial;

    // one trial subtraction
    always_comb
    begin
        rem_sh = {rem_reg[34:0], rad_reg[65:64]};
        trial  = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[63:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[31:0], 1'b0};
            end
        end
        else if (fin_reg)
        begin
            // round to nearest
            if (rem_reg > {4'b0000, root_reg})
                root_reg <= root_reg + 33'd1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> design/wsc_cordic.sv
// ----------------------------------------------------------------------------
// wsc_cordic
// vectoring cordic bearing of an offset, one rotation per cycle
// ----------------------------------------------------------------------------
module wsc_cordic
    import wsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] dx,
    input  logic signed [32:0] dy,
    output logic               done,
    output logic [31:0]        bearing
);

    cor_phase_t         phase_reg;
    cor_phase_t         phase_next;
    logic signed [44:0] x_reg;
    logic signed [44:0] y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         it_reg;
    logic               negx_reg;
    logic               negy_reg;
    logic [31:0]        bearing_reg;
    logic               done_reg;
    logic               done_next;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic signed [44:0] xs;
    logic signed [44:0] ys;
    logic signed [33:0] ang;
    logic signed [33:0] zc;
    logic [31:0]        t0;
    logic [31:0]        t1;

    always_comb
    begin
        ax  = dx[32] ? 33'(-dx) : 33'(dx);
        ay  = dy[32] ? 33'(-dy) : 33'(dy);
        xs  = x_reg >>> it_reg;
        ys  = y_reg >>> it_reg;
        ang = {2'b00, cordic_angle(it_reg)};
        // clamp to the first quadrant, then unfold by the offset signs
        if (z_reg < 34'sd0)
            zc = 34'sd0;
        else if (z_reg > QUARTER_TURN)
            zc = QUARTER_TURN;
        else
            zc = z_reg;
        t0 = negx_reg ? (32'h8000_0000 - zc[31:0]) : zc[31:0];
        t1 = negy_reg ? (32'd0 - t0) : t0;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            COR_IDLE:
            begin
                if (start && !(ax == 33'd0 && ay == 33'd0))
                    phase_next = COR_NORM;
            end
            COR_NORM:
            begin
                if ((x_reg[44:40] | y_reg[44:40]) != 5'd0)
                    phase_next = COR_ITER;
            end
            COR_ITER:
            begin
                if (it_reg == 5'd31)
                    phase_next = COR_FIN;
            end
            COR_FIN:
            begin
                phase_next = COR_IDLE;
            end
            default:
            begin
                phase_next = COR_IDLE;
            end
        endcase
    end

    // completion flag, at once for a zero offset
    always_comb
    begin
        done_next = ((phase_reg == COR_IDLE) && start && (ax == 33'd0) && (ay == 33'd0))
                  || (phase_reg == COR_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= COR_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            COR_IDLE:
            begin
                if (start)
                begin
                    x_reg       <= {12'd0, ax};
                    y_reg       <= {12'd0, ay};
                    z_reg       <= '0;
                    it_reg      <= '0;
                    negx_reg    <= dx[32];
                    negy_reg    <= dy[32];
                    bearing_reg <= '0;
                end
            end
            COR_NORM:
            begin
                // scale both up until the larger reaches 2^40
                if ((x_reg[44:40] | y_reg[44:40]) == 5'd0)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            COR_ITER:
            begin
                if (y_reg > 45'sd0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                it_reg <= it_reg + 5'd1;
            end
            COR_FIN:
            begin
                bearing_reg <= t1;
            end
            default:
            begin
                bearing_reg <= bearing_reg;
            end
        endcase
    end

    assign done    = done_reg;
    assign bearing = bearing_reg;

endmodule

>>> design/waypoint_steering_controller.sv
// ----------------------------------------------------------------------------
// waypoint_steering_controller
// heading pid and distance pd toward a configured waypoint, one result per item
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_stall is high from acceptance until the
// result is handed to the output register. The time an item takes is set by
// the shared bit-serial multiplier, which forms up to seven products, the
// cordic (up to 40 normalising shifts and 32 rotations) and the square root
// loop, and is least when both stages are skipped. The output register
// lets the next item be accepted while a result still waits to be taken. The
// configuration port is always ready.
module waypoint_steering_controller
    import wsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] yaw_rate_cmd,
    output logic [20:0]        speed_cmd,
    output logic signed [16:0] heading_error,
    output logic [32:0]        distance_to_target,
    output logic               arrived,
    output logic               position_reached
);

    // configuration
    logic signed [31:0] target_x_reg;
    logic signed [31:0] target_y_reg;
    logic [31:0]        head_p_reg;
    logic [31:0]        head_i_reg;
    logic [31:0]        head_d_reg;
    logic [31:0]        dist_p_reg;
    logic [31:0]        dist_d_reg;
    logic [20:0]        speed_lim_reg;

    // controller state
    logic signed [16:0] gate_herr_reg;
    logic signed [16:0] prev_herr_reg;
    logic signed [31:0] herr_sum_reg;
    logic [32:0]        gate_dist_reg;
    logic [32:0]        prev_dist_reg;

    // per item
    wsc_state_t         state_reg;
    wsc_state_t         state_next;
    wsc_job_t           job_reg;
    logic               issued_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [15:0]        hdg_reg;
    logic signed [16:0] err_reg;
    logic signed [31:0] sum_reg;
    logic [32:0]        dist_reg;
    logic [65:0]        sqx_reg;
    logic signed [55:0] acc_reg;
    logic signed [16:0] yaw_reg;
    logic [20:0]        speed_reg;
    logic               arrived_reg;
    logic               reached_reg;

    // output register
    logic               out_valid_reg;
    logic signed [16:0] yaw_out_reg;
    logic [20:0]        speed_out_reg;
    logic signed [16:0] herr_out_reg;
    logic [32:0]        dist_out_reg;
    logic               arrived_out_reg;
    logic               reached_out_reg;

    // unit handshakes
    logic               cor_start;
    logic               cor_done;
    logic [31:0]        cor_bearing;
    logic               mul_start;
    logic               mul_done;
    logic [2*MW-1:0]    mul_prod;
    logic [MW-1:0]      mul_a;
    logic [MW-1:0]      mul_b;
    logic               sq_start;
    logic               sq_done;
    logic [32:0]        sq_root;
    logic [65:0]        sq_rad;

    // combinational datapath
    logic               dist_ok;
    logic               herr_ok;
    logic [31:0]        e32;
    logic signed [39:0] e_prod;
    logic signed [39:0] e_rnd;
    logic signed [16:0] err_val;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic signed [34:0] gval;
    logic [34:0]        gmag;
    logic               gneg;
    logic [55:0]        term;
    logic signed [55:0] acc_add;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic signed [16:0] yaw_val;
    logic [20:0]        speed_val;
    logic               out_free;

    wsc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .done    (cor_done),
        .bearing (cor_bearing)
    );

    wsc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    wsc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (sq_rad),
        .done  (sq_done),
        .root  (sq_root)
    );

    // gates, heading error, integral and offset magnitudes
    always_comb
    begin
        dist_ok  = gate_dist_reg >= ARRIVE_MIN;
        herr_ok  = (gate_herr_reg < GATE_DEG) && (gate_herr_reg > -GATE_DEG);
        e32      = cor_bearing - {hdg_reg, 16'h0000};
        e_prod   = $signed({{8{e32[31]}}, e32}) * 40'sd45;
        e_rnd    = e_prod + 40'sd1048576;
        err_val  = e_rnd[37:21];
        sum_wide = 33'(err_val) + 33'(herr_sum_reg);
        if (sum_wide[32] != sum_wide[31])
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            sum_sat = sum_wide[31:0];
        adx = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ady = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    end

    // multiplier operands for the current product, its accumulation and the radicand
    always_comb
    begin
        gval  = 35'sd0;
        mul_b = '0;
        case (job_reg)
            J_HP:
            begin
                gval  = 35'(err_reg);
                mul_b = {1'b0, head_p_reg};
            end
            J_HD:
            begin
                gval  = 35'(err_reg) - 35'(prev_herr_reg);
                mul_b = {1'b0, head_d_reg};
            end
            J_HI:
            begin
                gval  = 35'(sum_reg);
                mul_b = {1'b0, head_i_reg};
            end
            J_SQX:
            begin
                gval  = $signed({2'b00, adx});
                mul_b = adx;
            end
            J_SQY:
            begin
                gval  = $signed({2'b00, ady});
                mul_b = ady;
            end
            J_DP:
            begin
                gval  = $signed({2'b00, dist_reg});
                mul_b = {1'b0, dist_p_reg};
            end
            J_DD:
            begin
                gval  = $signed({2'b00, dist_reg}) - $signed({2'b00, prev_dist_reg});
                mul_b = {1'b0, dist_d_reg};
            end
            default:
            begin
                gval  = 35'sd0;
                mul_b = '0;
            end
        endcase
        gneg  = gval[34];
        gmag  = gneg ? 35'(-gval) : 35'(gval);
        mul_a = gmag[MW-1:0];
        // heading gains drop 16 fraction bits, distance gains 24
        if (job_reg == J_DP || job_reg == J_DD)
            term = {14'd0, mul_prod[65:24]};
        else
            term = {6'd0, mul_prod[65:16]};
        acc_add = gneg ? (acc_reg - $signed(term)) : (acc_reg + $signed(term));
        sq_rad  = sqx_reg + mul_prod;
    end

    // command clamps
    always_comb
    begin
        if (acc_reg > YAW_MAX)
            yaw_val = 17'(YAW_MAX);
        else if (acc_reg < -YAW_MAX)
            yaw_val = 17'(-YAW_MAX);
        else
            yaw_val = acc_reg[16:0];
        if ((err_reg < DEAD_DEG) && (err_reg > -DEAD_DEG))
            yaw_val = 17'sd0;
        if (acc_reg <= 56'sd0)
            speed_val = 21'd0;
        else if (acc_reg >= $signed({35'd0, speed_lim_reg}))
            speed_val = speed_lim_reg;
        else
            speed_val = acc_reg[20:0];
        if (dist_reg < REACH_LIMIT)
            speed_val = 21'd0;
    end

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_HGATE;
            end
            ST_HGATE:
            begin
                state_next = dist_ok ? ST_BEAR : ST_DGATE;
            end
            ST_BEAR:
            begin
                if (cor_done)
                    state_next = ST_ERR;
            end
            ST_ERR:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    case (job_reg)
                        J_HI:    state_next = ST_HFIN;
                        J_SQY:   state_next = ST_ROOT;
                        J_DD:    state_next = ST_DFIN;
                        default: state_next = ST_MUL;
                    endcase
                end
            end
            ST_HFIN:
            begin
                state_next = ST_DGATE;
            end
            ST_DGATE:
            begin
                state_next = herr_ok ? ST_MUL : ST_OUT;
            end
            ST_ROOT:
            begin
                if (sq_done)
                    state_next = ST_MUL;
            end
            ST_DFIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controls
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cor_start = (state_reg == ST_HGATE) && dist_ok;
        mul_start = (state_reg == ST_MUL) && !issued_reg;
        sq_start  = (state_reg == ST_MUL) && (job_reg == J_SQY) && mul_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start)
                issued_reg <= 1'b1;
            else if (mul_done)
                issued_reg <= 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            head_p_reg    <= RST_HEAD_P;
            head_i_reg    <= RST_HEAD_I;
            head_d_reg    <= RST_HEAD_D;
            dist_p_reg    <= RST_DIST_P;
            dist_d_reg    <= RST_DIST_D;
            speed_lim_reg <= RST_SPEED_LIM;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_X:  target_x_reg  <= cfg_data;
                CFG_TARGET_Y:  target_y_reg  <= cfg_data;
                CFG_HEAD_P:    head_p_reg    <= cfg_data;
                CFG_HEAD_I:    head_i_reg    <= cfg_data;
                CFG_HEAD_D:    head_d_reg    <= cfg_data;
                CFG_DIST_P:    dist_p_reg    <= cfg_data;
                CFG_DIST_D:    dist_d_reg    <= cfg_data;
                CFG_SPEED_LIM: speed_lim_reg <= cfg_data[20:0];
                default:       speed_lim_reg <= speed_lim_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // controller state, updated only by the stages that run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_herr_reg <= RESET_GATE_DEG;
            prev_herr_reg <= '0;
            herr_sum_reg  <= '0;
            gate_dist_reg <= RESET_GATE_DIST;
            prev_dist_reg <= '0;
        end
        else if (state_reg == ST_HFIN)
        begin
            gate_herr_reg <= err_reg;
            prev_herr_reg <= err_reg;
            herr_sum_reg  <= sum_reg;
        end
        else if (state_reg == ST_DFIN)
        begin
            gate_dist_reg <= dist_reg;
            prev_dist_reg <= dist_reg;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dx_reg      <= 33'(target_x_reg) - 33'(pos_x);
                    dy_reg      <= 33'(target_y_reg) - 33'(pos_y);
                    hdg_reg     <= heading;
                    yaw_reg     <= '0;
                    speed_reg   <= '0;
                    arrived_reg <= 1'b0;
                    reached_reg <= 1'b0;
                end
            end
            ST_HGATE:
            begin
                if (!dist_ok)
                    arrived_reg <= 1'b1;
            end
            ST_ERR:
            begin
                err_reg <= err_val;
                sum_reg <= sum_sat;
                acc_reg <= '0;
                job_reg <= J_HP;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    case (job_reg)
                        J_HP:
                        begin
                            acc_reg <= acc_add;
                            job_reg <= J_HD;
                        end
                        J_HD:
                        begin
                            acc_reg <= acc_add;
                            job_reg <= J_HI;
                        end
                        J_HI:
                        begin
                            acc_reg <= acc_add;
                        end
                        J_SQX:
                        begin
                            sqx_reg <= mul_prod;
                            job_reg <= J_SQY;
                        end
                        J_DP:
                        begin
                            acc_reg <= acc_add;
                            job_reg <= J_DD;
                        end
                        J_DD:
                        begin
                            acc_reg <= acc_add;
                        end
                        default:
                        begin
                            acc_reg <= acc_reg;
                        end
                    endcase
                end
            end
            ST_HFIN:
            begin
                yaw_reg <= yaw_val;
            end
            ST_DGATE:
            begin
                if (herr_ok)
                    job_reg <= J_SQX;
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    dist_reg <= sq_root;
                    acc_reg  <= '0;
                    job_reg  <= J_DP;
                end
            end
            ST_DFIN:
            begin
                speed_reg   <= speed_val;
                reached_reg <= (dist_reg < REACH_LIMIT);
            end
            default:
            begin
                yaw_reg <= yaw_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            yaw_out_reg     <= yaw_reg;
            speed_out_reg   <= speed_reg;
            herr_out_reg    <= gate_herr_reg;
            dist_out_reg    <= gate_dist_reg;
            arrived_out_reg <= arrived_reg;
            reached_out_reg <= reached_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign yaw_rate_cmd       = yaw_out_reg;
    assign speed_cmd          = speed_out_reg;
    assign heading_error      = herr_out_reg;
    assign distance_to_target = dist_out_reg;
    assign arrived            = arrived_out_reg;
    assign position_reached   = reached_out_reg;

endmodule
